/* rtl/core/ded_pkg.sv */
package ded_pkg;

	typedef struct packed {
		logic [7:0] kind;
		logic [7:0] arg;
	} entry_t;

	// result status codes
	localparam logic [2:0] ST_ADDED = 3'd0;
	localparam logic [2:0] ST_DUP   = 3'd1;
	localparam logic [2:0] ST_FULL  = 3'd2;
	localparam logic [2:0] ST_POP   = 3'd3;
	localparam logic [2:0] ST_EMPTY = 3'd4;

	// operation codes; any code with the high bit set is a pop
	localparam logic [1:0] FUNC_PUSH_TAIL = 2'd0;
	localparam logic [1:0] FUNC_PUSH_HEAD = 2'd1;
	localparam int         FUNC_POP_BIT   = 1;

endpackage

/* rtl/core/ded_store.sv */
module ded_store import ded_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  entry_t                   wr_data,
	input  entry_t                   key,
	output entry_t                   rd_data,
	output logic                     match
);

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	// single comparator, shared by every step of the duplicate scan
	assign match   = (rd_data_q == key);
	assign rd_data = rd_data_q;

endmodule

/* rtl/core/dedup_event_deque.sv */
// Bounded event deque with duplicate suppression. Each transfer on the req
// channel is one operation: push tail, push head, or pop head (func high bit
// set). A push first scans every queued entry for an identical kind/arg pair
// through one RAM read port and one comparator, one entry per cycle, then moves
// to S_DONE, which loads the output register; a pop reads the head slot in
// S_POP_RD before S_DONE, and a pop on an empty queue goes straight to S_DONE.
// A stalled result holds the next item in S_DONE until
// the output register frees up. req_stall is high while an item is in
// work. Entries live in a circular buffer, so pushes and pops never move data.
// A refused push for lack of space bumps a wrapping 8-bit drop counter, whose
// value after each item is reported in drop_count. No clearing pass is needed
// after reset: only slots holding queued entries are ever read.
module dedup_event_deque import ded_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  logic [1:0] func,
	input  logic [7:0] event_kind,
	input  logic [7:0] event_arg,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output logic [2:0] status,
	output logic [7:0] out_kind,
	output logic [7:0] out_arg,
	output logic [7:0] drop_count
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_POP_RD = 4'b0100,
		S_DONE   = 4'b1000
	} state_t;

	state_t        state_q;
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [7:0]    dropped_q;
	logic [AW-1:0] ptr_q;
	logic [CW-1:0] idx_q;
	logic          pend_q;
	logic          match_q;
	logic          at_head_q;
	entry_t        word_q;

	logic [2:0]    res_status_q;
	entry_t        res_entry_q;
	logic          rsp_valid_q;
	logic [2:0]    status_q;
	entry_t        out_entry_q;
	logic [7:0]    drop_count_q;

	logic          accept;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic          scan_rd;
	logic          scan_end;
	entry_t        rd_data;
	logic          cmp_match;
	logic          out_free;

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
	endfunction

	function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - AW'(1);
	endfunction

	assign req_stall = (state_q != S_IDLE);
	assign accept    = req_valid && (state_q == S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign scan_rd  = (state_q == S_SCAN) && (idx_q < count_q);
	assign scan_end = (state_q == S_SCAN) && !scan_rd && !pend_q;

	always_comb begin
		rd_en   = scan_rd;
		rd_addr = ptr_q;
		if (state_q == S_IDLE) begin
			rd_en   = accept && func[FUNC_POP_BIT] && (count_q != '0);
			rd_addr = head_q;
		end
	end

	// after the scan ptr_q has walked past the last entry: the tail slot
	assign wr_en   = scan_end && !match_q && (count_q != CW'(DEPTH));
	assign wr_addr = at_head_q ? ptr_dec(head_q) : ptr_q;

	ded_store #(
		.DEPTH(DEPTH)
	) u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (word_q),
		.key     (word_q),
		.rd_data (rd_data),
		.match   (cmp_match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			dropped_q    <= '0;
			ptr_q        <= '0;
			idx_q        <= '0;
			pend_q       <= 1'b0;
			match_q      <= 1'b0;
			at_head_q    <= 1'b0;
			word_q       <= '0;
			res_status_q <= ST_ADDED;
			res_entry_q  <= '0;
			rsp_valid_q  <= 1'b0;
			status_q     <= ST_ADDED;
			out_entry_q  <= '0;
			drop_count_q <= '0;
		end else begin
			// S_DONE owns rsp_valid_q while it is loading a result
			if (rsp_valid_q && !rsp_stall && (state_q != S_DONE)) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						word_q    <= '{kind: event_kind, arg: event_arg};
						at_head_q <= (func == FUNC_PUSH_HEAD);
						ptr_q     <= head_q;
						idx_q     <= '0;
						pend_q    <= 1'b0;
						match_q   <= 1'b0;
						if (func[FUNC_POP_BIT]) begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
								res_entry_q  <= '0;
								state_q      <= S_DONE;
							end else begin
								state_q <= S_POP_RD;
							end
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					pend_q <= scan_rd;
					if (scan_rd) begin
						ptr_q <= ptr_inc(ptr_q);
						idx_q <= idx_q + CW'(1);
					end
					if (pend_q && cmp_match) begin
						match_q <= 1'b1;
					end
					if (scan_end) begin
						res_entry_q <= '0;
						state_q     <= S_DONE;
						if (match_q) begin
							res_status_q <= ST_DUP;
						end else if (count_q == CW'(DEPTH)) begin
							res_status_q <= ST_FULL;
							dropped_q    <= dropped_q + 8'd1;
						end else begin
							res_status_q <= ST_ADDED;
							count_q      <= count_q + CW'(1);
							if (at_head_q) begin
								head_q <= ptr_dec(head_q);
							end
						end
					end
				end
				S_POP_RD: begin
					res_status_q <= ST_POP;
					res_entry_q  <= rd_data;
					head_q       <= ptr_inc(head_q);
					count_q      <= count_q - CW'(1);
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (out_free) begin
						rsp_valid_q  <= 1'b1;
						status_q     <= res_status_q;
						out_entry_q  <= res_entry_q;
						drop_count_q <= dropped_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign out_kind   = out_entry_q.kind;
	assign out_arg    = out_entry_q.arg;
	assign drop_count = drop_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill level beyond depth");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + CW'(1)) || (count_q == $past(count_q) - CW'(1))))
		else $error("fill level moved by more than one");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP_RD) |-> (count_q != '0))
		else $error("pop read issued on empty queue");

	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (status_q != ST_POP)) |-> (out_entry_q == '0))
		else $error("non-pop result carries event data");

	a_drop_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_end && !match_q && (count_q == CW'(DEPTH))) |=>
		(dropped_q == $past(dropped_q) + 8'd1))
		else $error("full refusal did not count a drop");

endmodule
